// ----- rtl/pba_pkg.sv -----
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants for the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 13;
    localparam int CFG_W      = 13;
    localparam int PAGE_SHIFT = 12;
    // page positions: a 20-bit page number plus a 13-bit count fits in 21 bits
    localparam int POS_W      = 21;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_MISALIGN   = 2'd2,
        ST_ZERO_COUNT = 2'd3
    } t_status;

    typedef struct packed {
        logic    load;
        logic    init_scan;
        logic    scan;
        logic    set_mark;
        logic    init_free;
        logic    walk;
        logic    push;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic misaligned;
        logic zero_count;
        logic scan_end;
        logic rd_vld;
        logic hit;
        logic walk_done;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- rtl/pba_datapath.sv -----
// ----------------------------------------------------------------------------
// pba_datapath
// Page used map, scan and walk pointers, run counter and result register.
// ----------------------------------------------------------------------------
module pba_datapath #(
    parameter int MAX_PAGES = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pba_pkg::t_dp_cmd                i_cmd,
    output pba_pkg::t_dp_sts                o_sts,
    input  logic [pba_pkg::CFG_W-1:0]       i_total_pages,
    input  logic [pba_pkg::CFG_W-1:0]       i_reserved_pages,
    input  logic                            i_action,
    input  logic [pba_pkg::ADDR_W-1:0]      i_address,
    input  logic [pba_pkg::COUNT_W-1:0]     i_count,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [pba_pkg::ADDR_W-1:0]      o_page_address,
    output logic [1:0]                      o_status
);
    import pba_pkg::*;

    localparam int PW = $clog2(MAX_PAGES);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PAGES);

    logic                 r_map [MAX_PAGES];
    logic                 r_rd_bit;
    logic                 r_rd_vld;
    logic [POS_W-1:0]     r_rd_idx;
    logic [POS_W-1:0]     r_idx;
    logic [POS_W-1:0]     r_end;
    logic                 r_wval;
    logic [COUNT_W-1:0]   r_run;
    logic [POS_W-1:0]     r_start;
    logic                 r_action;
    logic [ADDR_W-1:0]    r_address;
    logic [COUNT_W-1:0]   r_count;
    logic                 r_out_valid;
    logic [ADDR_W-1:0]    r_out_addr;
    logic [1:0]           r_out_status;

    logic [POS_W-1:0]     tot_ext;
    logic [POS_W-1:0]     eff_total;
    logic [POS_W-1:0]     free_first;
    logic [POS_W-1:0]     free_end_raw;
    logic [POS_W-1:0]     free_end;
    logic [POS_W-1:0]     hit_end;
    logic [COUNT_W:0]     run_next;
    logic                 scan_end;
    logic                 rd_en;
    logic                 wr_en;
    logic                 walk_done;
    logic                 hit;

    assign tot_ext      = POS_W'(i_total_pages);
    assign eff_total    = (tot_ext < MAX_POS) ? tot_ext : MAX_POS;
    assign free_first   = POS_W'(r_address[ADDR_W-1:PAGE_SHIFT]);
    assign free_end_raw = free_first + POS_W'(r_count);
    assign free_end     = (free_end_raw < eff_total) ? free_end_raw : eff_total;
    assign hit_end      = r_rd_idx + POS_W'(1);
    assign run_next     = {1'b0, r_run} + (COUNT_W+1)'(1);
    assign scan_end     = (r_idx >= eff_total);
    assign rd_en        = i_cmd.scan && !scan_end;
    assign walk_done    = (r_idx >= r_end);
    assign wr_en        = i_cmd.walk && !walk_done;
    assign hit          = r_rd_vld && !r_rd_bit && (run_next == {1'b0, r_count});

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[r_idx[PW-1:0]] <= r_wval;
        end
        if (rd_en) begin
            r_rd_bit <= r_map[r_idx[PW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_end       <= MAX_POS;
            r_wval      <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            if (i_cmd.set_mark) begin
                r_idx  <= hit_end - POS_W'(r_count);
                r_end  <= hit_end;
                r_wval <= 1'b1;
            end else if (i_cmd.init_free) begin
                r_idx  <= free_first;
                r_end  <= free_end;
                r_wval <= 1'b0;
            end else if (i_cmd.init_scan) begin
                r_idx <= POS_W'(i_reserved_pages);
            end else if (rd_en || wr_en) begin
                r_idx <= r_idx + POS_W'(1);
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_idx <= r_idx;
        end
        if (i_cmd.init_scan) begin
            r_run <= '0;
        end else if (r_rd_vld) begin
            r_run <= r_rd_bit ? '0 : run_next[COUNT_W-1:0];
        end
        if (i_cmd.set_mark) begin
            r_start <= hit_end - POS_W'(r_count);
        end
        if (i_cmd.load) begin
            r_action  <= i_action;
            r_address <= i_address;
            r_count   <= i_count;
        end
        if (i_cmd.push) begin
            r_out_status <= i_cmd.code;
            if (i_cmd.code == ST_OK && !r_action) begin
                r_out_addr <= ADDR_W'({r_start, {PAGE_SHIFT{1'b0}}});
            end else begin
                r_out_addr <= '0;
            end
        end
    end

    assign o_sts.is_free    = r_action;
    assign o_sts.misaligned = (r_address[PAGE_SHIFT-1:0] != '0);
    assign o_sts.zero_count = (r_count == '0);
    assign o_sts.scan_end   = scan_end;
    assign o_sts.rd_vld     = r_rd_vld;
    assign o_sts.hit        = hit;
    assign o_sts.walk_done  = walk_done;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_page_address = r_out_addr;
    assign o_status       = r_out_status;

endmodule

// ----- rtl/pba_ctrl.sv -----
// ----------------------------------------------------------------------------
// pba_ctrl
// Sequencer for map clear, request decode, first-fit scan, run walk and reply.
// ----------------------------------------------------------------------------
module pba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  pba_pkg::t_dp_sts  i_sts,
    output pba_pkg::t_dp_cmd  o_cmd
);
    import pba_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_WALK,
        S_RESP
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_status r_code;
    t_status n_code;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.code = r_code;
        case (r_state)
            S_CLEAR: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_free && i_sts.misaligned) begin
                    n_code  = ST_MISALIGN;
                    n_state = S_RESP;
                end else if (i_sts.zero_count) begin
                    n_code  = ST_ZERO_COUNT;
                    n_state = S_RESP;
                end else if (i_sts.is_free) begin
                    o_cmd.init_free = 1'b1;
                    n_code  = ST_OK;
                    n_state = S_WALK;
                end else begin
                    o_cmd.init_scan = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.set_mark = 1'b1;
                    n_code  = ST_OK;
                    n_state = S_WALK;
                end else if (!i_sts.rd_vld && i_sts.scan_end) begin
                    n_code  = ST_NO_SPACE;
                    n_state = S_RESP;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

`ifndef NO_ASSERTIONS
    a_push_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> i_sts.out_free)
        else $error("reply pushed over a pending result");

    a_hit_to_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_sts.hit) |=> (r_state == S_WALK))
        else $error("found run not marked");

    a_walk_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && !i_sts.walk_done) |=> (r_state == S_WALK))
        else $error("run walk left early");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_DECODE && !o_req_ready))
        else $error("request accepted while busy");
`endif

endmodule

// ----- rtl/page_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// First-fit allocator of contiguous 4 KiB pages over a one-bit-per-page map.
//
// Requests enter on s_axis: tuser[0] selects allocate (0) or free (1), tdata
// carries the free address and the page count. One reply per request leaves
// on m_axis with the run's byte address and a status code. Page total and
// reserved page count must be set over the APB port while no request is open;
// the block does not enforce it. After reset the map is swept clear, one page
// a cycle; s_axis_tready stays low until the sweep ends. An allocate scans
// from the reserved boundary to the end of the found run, then marks that run
// page by page; a failed allocate scans to the page total. A free clears its
// pages one by one, stopping at the page total.
// A new request is taken while a finished reply waits in the output register;
// if m_axis stalls, the next reply waits until that register drains.
// ----------------------------------------------------------------------------
module page_bitmap_allocator #(
    parameter int MAX_PAGES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // address[31:0], count[44:32], zero pad
    input  logic [0:0]  s_axis_tuser,   // action[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // page_address[31:0], status[33:32], pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pba_pkg::*;

    localparam int REG_TOTAL    = 0;
    localparam int REG_RESERVED = 1;

    logic [CFG_W-1:0]   r_total_pages;
    logic [CFG_W-1:0]   r_reserved_pages;
    t_dp_cmd            cmd;
    t_dp_sts            sts;
    logic [ADDR_W-1:0]  page_address;
    logic [1:0]         status;
    logic               cfg_wr;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_pages    <= CFG_W'(4096);
            r_reserved_pages <= CFG_W'(256);
        end else if (cfg_wr) begin
            if (reg_sel == 1'(REG_TOTAL)) begin
                r_total_pages <= pwdata[CFG_W-1:0];
            end else begin
                r_reserved_pages <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (reg_sel == 1'(REG_RESERVED)) ? 32'(r_reserved_pages)
                                                  : 32'(r_total_pages);

    pba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pba_datapath #(
        .MAX_PAGES (MAX_PAGES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_total_pages    (r_total_pages),
        .i_reserved_pages (r_reserved_pages),
        .i_action         (s_axis_tuser[0]),
        .i_address        (s_axis_tdata[ADDR_W-1:0]),
        .i_count          (s_axis_tdata[ADDR_W+COUNT_W-1:ADDR_W]),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_page_address   (page_address),
        .o_status         (status)
    );

    assign m_axis_tdata = {6'b0, status, page_address};

endmodule

// ----- dv/tb_page_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_page_bitmap_allocator
// Self-checking bench for the first-fit page bitmap allocator. A directed table
// covers status codes, full-map runs and register extremes. Random phases then
// mix allocates with frees of live runs under bursty requests and a stalling
// reply side. Each reply is checked against a directed value or a local page map model.
// ----------------------------------------------------------------------------
module tb_page_bitmap_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import pba_pkg::*;

    localparam int MAX_PAGES        = 4096;
    localparam int WATCHDOG_LIMIT   = 100000;
    localparam int DIRECTED_ROWS    = 29;
    localparam int RANDOM_PHASES    = 6;
    localparam int RANDOM_PER_PHASE = 20;

    typedef enum logic {ACT_ALLOC = 1'b0, ACT_FREE = 1'b1} t_action;
    typedef enum logic {REG_TOTAL_PAGES = 1'b0, REG_RESERVED_PAGES = 1'b1} t_reg;
    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_HOLD} t_rx_mode;

    typedef struct packed {
        logic [31:0] page_address;
        t_status     status;
    } t_reply;

    typedef struct packed {
        logic [31:0] address;
        logic [12:0] count;
    } t_run;

    typedef struct packed {
        t_row_kind   kind;
        t_action     action;
        logic [31:0] address;
        logic [12:0] count;
        t_reg        reg_sel;
        logic [12:0] reg_value;
        logic        typed;
        t_reply      known;
    } t_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;   // address[31:0], count[44:32], zero pad
    logic [0:0]  s_axis_tuser  = '0;   // action[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // page_address[31:0], status[33:32], pad
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        pages_taken [MAX_PAGES];
    logic [12:0] cfg_page_total    = 13'd4096;
    logic [12:0] cfg_page_reserved = 13'd256;
    t_reply      pending_replies [$];
    t_run        live_runs [$];
    int          burst_left  = 1;
    int          error_count = 0;
    int          idle_cycles = 0;
    t_rx_mode    rx_mode     = RX_OPEN;
    int          rx_window   = 0;
    t_row        directed_rows [DIRECTED_ROWS];

    page_bitmap_allocator #(.MAX_PAGES(MAX_PAGES)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_reply predict_request(t_action act, logic [31:0] addr,
                                               logic [12:0] cnt);
        t_reply r;
        int     eff;
        int     run;
        int     start;
        int     p;
        longint first;
        longint q;
        logic   found;
        r.page_address = '0;
        r.status       = ST_OK;
        eff   = (int'(cfg_page_total) > MAX_PAGES) ? MAX_PAGES : int'(cfg_page_total);
        run   = 0;
        start = 0;
        found = 1'b0;
        if (act == ACT_ALLOC) begin
            if (cnt == '0) begin
                r.status = ST_ZERO_COUNT;
            end else begin
                for (p = int'(cfg_page_reserved); p < eff && !found; p++) begin
                    if (pages_taken[p]) begin
                        run = 0;
                    end else begin
                        run++;
                        if (run == int'(cnt)) begin
                            start = p + 1 - int'(cnt);
                            found = 1'b1;
                        end
                    end
                end
                if (found) begin
                    for (p = start; p < start + int'(cnt); p++) pages_taken[p] = 1'b1;
                    r.page_address = 32'(start << PAGE_SHIFT);
                end else begin
                    r.status = ST_NO_SPACE;
                end
            end
        end else if (addr[PAGE_SHIFT-1:0] != '0) begin
            r.status = ST_MISALIGN;
        end else if (cnt == '0) begin
            r.status = ST_ZERO_COUNT;
        end else begin
            first = longint'(addr >> PAGE_SHIFT);
            for (q = first; q < first + longint'(cnt) && q < longint'(eff); q++)
                pages_taken[int'(q)] = 1'b0;
        end
        return r;
    endfunction

    function automatic t_row req_row(t_action act, logic [31:0] addr, logic [12:0] cnt);
        t_row row;
        row           = '0;
        row.kind      = ROW_REQ;
        row.action    = act;
        row.address   = addr;
        row.count     = cnt;
        return row;
    endfunction

    function automatic t_row req_known(t_action act, logic [31:0] addr, logic [12:0] cnt,
                                       logic [31:0] exp_addr, t_status exp_status);
        t_row row;
        row                    = req_row(act, addr, cnt);
        row.typed              = 1'b1;
        row.known.page_address = exp_addr;
        row.known.status       = exp_status;
        return row;
    endfunction

    function automatic t_row cfg_row(t_reg sel, logic [12:0] value);
        t_row row;
        row           = '0;
        row.kind      = ROW_CFG;
        row.reg_sel   = sel;
        row.reg_value = value;
        return row;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("[%0t] MISMATCH %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
    endtask

    task automatic send_request(t_action act, logic [31:0] addr, logic [12:0] cnt,
                                logic typed, t_reply known);
        t_reply r;
        int     gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, cnt, addr};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        r = predict_request(act, addr, cnt);
        if (typed) r = known;
        pending_replies.push_back(r);
        if (act == ACT_ALLOC && r.status == ST_OK)
            live_runs.push_back(t_run'{address: r.page_address, count: cnt});
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = $urandom_range(0, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    task automatic write_register(t_reg sel, logic [12:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {19'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_TOTAL_PAGES) cfg_page_total = value;
        else cfg_page_reserved = value;
    endtask

    // reply side stall pattern
    always @(posedge i_clk) begin
        if (rx_window == 0) begin
            rx_mode   <= t_rx_mode'($urandom_range(0, 3));
            rx_window <= $urandom_range(16, 96);
        end else begin
            rx_window <= rx_window - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:   m_axis_tready <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("reply with no request open", m_axis_tdata[31:0], '0);
            end else begin
                want = pending_replies.pop_front();
                if (m_axis_tdata[31:0] !== want.page_address)
                    report_mismatch("page_address", m_axis_tdata[31:0], want.page_address);
                if (m_axis_tdata[33:32] !== want.status)
                    report_mismatch("status", 32'(m_axis_tdata[33:32]), 32'(want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        int          phase_total    [RANDOM_PHASES];
        int          phase_reserved [RANDOM_PHASES];
        int          eff;
        int          span;
        int          sel;
        int          idx;
        logic [31:0] addr;
        logic [12:0] cnt;
        t_run        run;
        t_reply      none;

        phase_total    = '{64, 40, 8191, 20, 130, 4096};
        phase_reserved = '{8, 0, 4090, 20, 100, 3968};
        none           = '0;
        foreach (pages_taken[p]) pages_taken[p] = 1'b0;

        directed_rows = '{
            req_known(ACT_ALLOC, 32'h0000_0000, 13'd0,    32'h0, ST_ZERO_COUNT),
            req_known(ACT_FREE,  32'h0000_1001, 13'd5,    32'h0, ST_MISALIGN),
            req_known(ACT_FREE,  32'hFFFF_FFFF, 13'd0,    32'h0, ST_MISALIGN),
            req_known(ACT_FREE,  32'h0000_0000, 13'd0,    32'h0, ST_ZERO_COUNT),
            req_known(ACT_ALLOC, 32'hFFFF_FFFF, 13'd1,    32'h0010_0000, ST_OK),
            req_known(ACT_ALLOC, 32'h0000_0000, 13'd3,    32'h0010_1000, ST_OK),
            req_known(ACT_FREE,  32'h0010_1000, 13'd1,    32'h0, ST_OK),
            req_row  (ACT_ALLOC, 32'h0000_0000, 13'd2),
            req_known(ACT_ALLOC, 32'h0000_0000, 13'd4096, 32'h0, ST_NO_SPACE),
            req_known(ACT_ALLOC, 32'h0000_0000, 13'd8191, 32'h0, ST_NO_SPACE),
            req_known(ACT_FREE,  32'hFFFF_F000, 13'd8191, 32'h0, ST_OK),
            req_known(ACT_FREE,  32'h0000_0000, 13'd4096, 32'h0, ST_OK),
            req_known(ACT_ALLOC, 32'h0000_0000, 13'd3840, 32'h0010_0000, ST_OK),
            req_known(ACT_ALLOC, 32'h0000_0000, 13'd1,    32'h0, ST_NO_SPACE),
            req_known(ACT_FREE,  32'h00FF_F000, 13'd1,    32'h0, ST_OK),
            req_row  (ACT_ALLOC, 32'h0000_0000, 13'd1),
            req_known(ACT_FREE,  32'h0010_0000, 13'd4096, 32'h0, ST_OK),
            cfg_row(REG_TOTAL_PAGES, 13'd8191),
            cfg_row(REG_RESERVED_PAGES, 13'd0),
            req_known(ACT_ALLOC, 32'h0000_0000, 13'd4096, 32'h0, ST_OK),
            req_known(ACT_FREE,  32'h0000_0000, 13'd8191, 32'h0, ST_OK),
            cfg_row(REG_RESERVED_PAGES, 13'd4096),
            req_known(ACT_ALLOC, 32'h0000_0000, 13'd1,    32'h0, ST_NO_SPACE),
            cfg_row(REG_RESERVED_PAGES, 13'd8191),
            req_known(ACT_ALLOC, 32'h0000_0000, 13'd1,    32'h0, ST_NO_SPACE),
            cfg_row(REG_TOTAL_PAGES, 13'd0),
            cfg_row(REG_RESERVED_PAGES, 13'd0),
            req_known(ACT_ALLOC, 32'h0000_0000, 13'd1,    32'h0, ST_NO_SPACE),
            req_known(ACT_FREE,  32'h0000_0000, 13'd3,    32'h0, ST_OK)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // hold until the page map sweep finishes
        do @(posedge i_clk); while (!s_axis_tready);

        foreach (directed_rows[n]) begin
            if (directed_rows[n].kind == ROW_CFG) begin
                drain_replies();
                write_register(directed_rows[n].reg_sel, directed_rows[n].reg_value);
            end else begin
                send_request(directed_rows[n].action, directed_rows[n].address,
                             directed_rows[n].count, directed_rows[n].typed,
                             directed_rows[n].known);
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_replies();
            write_register(REG_TOTAL_PAGES, 13'(phase_total[ph]));
            write_register(REG_RESERVED_PAGES, 13'(phase_reserved[ph]));
            eff  = (phase_total[ph] > MAX_PAGES) ? MAX_PAGES : phase_total[ph];
            span = (eff > phase_reserved[ph]) ? eff - phase_reserved[ph] : 0;
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 45) begin
                    if ($urandom_range(0, 19) == 0) cnt = 13'($urandom_range(1, 8191));
                    else cnt = 13'($urandom_range(1, span / 3 + 1));
                    send_request(ACT_ALLOC, $urandom, cnt, 1'b0, none);
                end else if (sel < 80 && live_runs.size() != 0) begin
                    idx = $urandom_range(0, live_runs.size() - 1);
                    run = live_runs[idx];
                    live_runs.delete(idx);
                    send_request(ACT_FREE, run.address, run.count, 1'b0, none);
                end else if (sel < 88) begin
                    if ($urandom_range(0, 3) == 0)
                        addr = {20'($urandom_range(0, 32'hFFFFF)), 12'h000};
                    else
                        addr = 32'((phase_reserved[ph] + $urandom_range(0, span + 4))
                                   << PAGE_SHIFT);
                    send_request(ACT_FREE, addr, 13'($urandom_range(1, 64)), 1'b0, none);
                end else if (sel < 95) begin
                    addr = $urandom;
                    if (addr[PAGE_SHIFT-1:0] == '0) addr[$urandom_range(0, PAGE_SHIFT-1)] = 1'b1;
                    send_request(ACT_FREE, addr, 13'($urandom_range(0, 8191)), 1'b0, none);
                end else begin
                    send_request(t_action'($urandom_range(0, 1)),
                                 {20'($urandom_range(0, 32'hFFFFF)), 12'h000}, 13'd0,
                                 1'b0, none);
                end
            end
        end

        drain_replies();
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/pba_pkg.sv
rtl/pba_datapath.sv
rtl/pba_ctrl.sv
rtl/page_bitmap_allocator.sv
dv/tb_page_bitmap_allocator.sv
